// File: hdl/esc_pkg.sv
`default_nettype none
package esc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CalW = 48;
  localparam int unsigned IdxW = 3;

  localparam logic [IdxW-1:0] RegTempCal = 3'd0;
  localparam logic [IdxW-1:0] RegPressCalA = 3'd1;
  localparam logic [IdxW-1:0] RegPressCalB = 3'd2;
  localparam logic [IdxW-1:0] RegPressCalC = 3'd3;
  localparam logic [IdxW-1:0] RegHumCalA = 3'd4;
  localparam logic [IdxW-1:0] RegHumCalB = 3'd5;

  typedef logic signed [DataW-1:0] word_t;

  typedef struct packed {
    word_t       tf;
    word_t       tc;
    logic [16:0] hum;
    logic        inv;
    logic        dbl;
  } side_t;

  // truncating division by 2**k
  function automatic word_t sdiv(input word_t x, input int unsigned k);
    word_t bias;
    bias = x[DataW-1] ? ((word_t'(1) <<< k) - word_t'(1)) : word_t'(0);
    return (x + bias) >>> k;
  endfunction

endpackage
`default_nettype wire

// File: hdl/env_sensor_compensation.sv
// each accepted start reaches the result strobe through the 32-stage restoring
// pressure divider plus 15 arithmetic stages
// throughput: one transaction per cycle, busy_o never rises
// the receiver cannot stall: every result is shown for one cycle only
// reset clears the calibration registers and all stage valid bits
`default_nettype none
module env_sensor_compensation (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire  [19:0]           raw_temperature_i,
  input  wire  [19:0]           raw_pressure_i,
  input  wire  [15:0]           raw_humidity_i,
  input  wire                   cfg_we_i,
  input  wire  [esc_pkg::IdxW-1:0] cfg_idx_i,
  input  wire  [esc_pkg::CalW-1:0] cfg_wdata_i,
  output logic                  result_valid_o,
  output logic signed [31:0]    fine_temperature_o,
  output logic signed [31:0]    temperature_centi_o,
  output logic [31:0]           pressure_o,
  output logic                  pressure_invalid_o,
  output logic [16:0]           humidity_value_o
);
  import esc_pkg::*;

  localparam int unsigned NStage = 47;
  localparam int unsigned DivN = 32;
  localparam int unsigned SideN = 35;

  logic [47:0] temp_cal_q, pca_q, pcb_q, pcc_q;
  logic [31:0] hca_q;
  logic [39:0] hcb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      pca_q <= '0;
      pcb_q <= '0;
      pcc_q <= '0;
      hca_q <= '0;
      hcb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTempCal:   temp_cal_q <= cfg_wdata_i;
        RegPressCalA: pca_q <= cfg_wdata_i;
        RegPressCalB: pcb_q <= cfg_wdata_i;
        RegPressCalC: pcc_q <= cfg_wdata_i;
        RegHumCalA:   hca_q <= cfg_wdata_i[31:0];
        RegHumCalB:   hcb_q <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
  assign t1 = word_t'({16'b0, temp_cal_q[15:0]});
  assign t2 = word_t'({{16{temp_cal_q[31]}}, temp_cal_q[31:16]});
  assign t3 = word_t'({{16{temp_cal_q[47]}}, temp_cal_q[47:32]});
  assign p1 = word_t'({16'b0, pca_q[15:0]});
  assign p2 = word_t'({{16{pca_q[31]}}, pca_q[31:16]});
  assign p3 = word_t'({{16{pca_q[47]}}, pca_q[47:32]});
  assign p4 = word_t'({{16{pcb_q[15]}}, pcb_q[15:0]});
  assign p5 = word_t'({{16{pcb_q[31]}}, pcb_q[31:16]});
  assign p6 = word_t'({{16{pcb_q[47]}}, pcb_q[47:32]});
  assign p7 = word_t'({{16{pcc_q[15]}}, pcc_q[15:0]});
  assign p8 = word_t'({{16{pcc_q[31]}}, pcc_q[31:16]});
  assign p9 = word_t'({{16{pcc_q[47]}}, pcc_q[47:32]});
  assign h1 = word_t'({24'b0, hca_q[7:0]});
  assign h2 = word_t'({{16{hca_q[23]}}, hca_q[23:8]});
  assign h3 = word_t'({24'b0, hca_q[31:24]});
  assign h4 = word_t'({{16{hcb_q[15]}}, hcb_q[15:0]});
  assign h5 = word_t'({{16{hcb_q[31]}}, hcb_q[31:16]});
  assign h6 = word_t'({{24{hcb_q[39]}}, hcb_q[39:32]});

  logic [NStage:1] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NStage-1:1], start_i};
    end
  end

  logic [19:0] rp_q [1:9];
  logic [15:0] rh_q [1:6];
  word_t       tf_q [5:13];
  word_t       tc_q [6:12];
  word_t s1_a0_q, s1_d_q, s2_am_q, s2_dd_q, s3_a_q, s3_bm_q, s5_tc5_q, s5_v1_q, s5_t_q;
  word_t s6_sq_q, s6_v1p5_q, s6_v4m_q, s6_z_q, s6_am_q, s6_bm_q;
  word_t s7_v2a_q, s7_v3m_q, s7_v4_q, s7_v1p5_q, s7_base_q, s7_ha_q, s7_hb_q;
  word_t s8_v2b_q, s8_v1c_q, s8_cm_q, s8_base_q;
  word_t s9_mp_q, s9_v2b_q, s9_gm_q, s9_base_q;
  word_t s10_v1d_q, s10_m_q, s11_nm_q, s11_m_q, s12_rm_q, s12_m_q;
  logic [31:0] s10_prp_q, s11_pr_q, s11_den_q, s12_num_q, s12_den_q;
  logic s11_inv_q, s12_dbl_q, s12_inv_q;
  word_t q6, r12;
  logic [16:0] hum12;

  assign q6 = sdiv(s5_v1_q, 2);
  assign r12 = s12_m_q - sdiv(s12_rm_q, 4);

  always_comb begin
    if (r12[31]) begin
      hum12 = 17'd0;
    end else if (r12 > word_t'(409600000)) begin
      hum12 = 17'd100000;
    end else begin
      hum12 = r12[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q[1] <= raw_pressure_i;
    for (int k = 2; k <= 9; k++) rp_q[k] <= rp_q[k-1];
    rh_q[1] <= raw_humidity_i;
    for (int k = 2; k <= 6; k++) rh_q[k] <= rh_q[k-1];
    for (int k = 6; k <= 13; k++) tf_q[k] <= tf_q[k-1];
    for (int k = 7; k <= 12; k++) tc_q[k] <= tc_q[k-1];
    // temperature
    s1_a0_q <= word_t'({15'b0, raw_temperature_i[19:3]}) - (t1 <<< 1);
    s1_d_q <= word_t'({16'b0, raw_temperature_i[19:4]}) - t1;
    s2_am_q <= s1_a0_q * t2;
    s2_dd_q <= s1_d_q * s1_d_q;
    s3_a_q <= sdiv(s2_am_q, 11);
    s3_bm_q <= sdiv(s2_dd_q, 12) * t3;
    tf_q[5] <= s3_a_q + sdiv(s3_bm_q, 14);
    s5_tc5_q <= tf_q[5] * word_t'(5) + word_t'(128);
    s5_v1_q <= sdiv(tf_q[5], 1) - word_t'(64000);
    s5_t_q <= tf_q[5] - word_t'(76800);
    tc_q[6] <= sdiv(s5_tc5_q, 8);
    // pressure and humidity
    s6_sq_q <= q6 * q6;
    s6_v1p5_q <= s5_v1_q * p5;
    s6_v4m_q <= p2 * s5_v1_q;
    s6_z_q <= h5 * s5_t_q;
    s6_am_q <= s5_t_q * h6;
    s6_bm_q <= s5_t_q * h3;
    s7_v2a_q <= sdiv(s6_sq_q, 11) * p6;
    s7_v3m_q <= p3 * sdiv(s6_sq_q, 13);
    s7_v4_q <= sdiv(s6_v4m_q, 1);
    s7_v1p5_q <= s6_v1p5_q;
    s7_base_q <= sdiv(word_t'({2'b0, rh_q[6], 14'b0}) - (h4 <<< 20) - s6_z_q
                      + word_t'(16384), 15);
    s7_ha_q <= sdiv(s6_am_q, 10);
    s7_hb_q <= sdiv(s6_bm_q, 11);
    s8_v2b_q <= sdiv(s7_v2a_q + (s7_v1p5_q <<< 1), 2) + (p4 <<< 16);
    s8_v1c_q <= sdiv(sdiv(s7_v3m_q, 3) + s7_v4_q, 18);
    s8_cm_q <= s7_ha_q * (s7_hb_q + word_t'(32768));
    s8_base_q <= s7_base_q;
    s9_mp_q <= (word_t'(32768) + s8_v1c_q) * p1;
    s9_v2b_q <= s8_v2b_q;
    s9_gm_q <= (sdiv(s8_cm_q, 10) + word_t'(2097152)) * h2;
    s9_base_q <= s8_base_q;
    s10_v1d_q <= sdiv(s9_mp_q, 15);
    s10_prp_q <= 32'd1048576 - {12'b0, rp_q[9]} - 32'(sdiv(s9_v2b_q, 12));
    s10_m_q <= s9_base_q * sdiv(s9_gm_q + word_t'(8192), 14);
    s11_pr_q <= s10_prp_q * 32'd3125;
    s11_den_q <= 32'(s10_v1d_q);
    s11_inv_q <= (s10_v1d_q == word_t'(0));
    s11_nm_q <= sdiv(s10_m_q, 15) * sdiv(s10_m_q, 15);
    s11_m_q <= s10_m_q;
    s12_num_q <= s11_pr_q[31] ? s11_pr_q : (s11_pr_q << 1);
    s12_dbl_q <= s11_pr_q[31];
    s12_den_q <= s11_den_q;
    s12_inv_q <= s11_inv_q;
    s12_rm_q <= sdiv(s11_nm_q, 7) * h1;
    s12_m_q <= s11_m_q;
  end

  // restoring divider, one quotient bit per stage
  logic [31:0] drem_q [0:DivN-1];
  logic [31:0] dnq_q [0:DivN-1];
  logic [31:0] dden_q [0:DivN-1];

  for (genvar j = 0; j < DivN; j++) begin : g_div
    logic [31:0] rem_in, nq_in, den_in;
    logic [32:0] trial, diff;
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in = s12_num_q;
      assign den_in = s12_den_q;
    end else begin : g_next
      assign rem_in = drem_q[j-1];
      assign nq_in = dnq_q[j-1];
      assign den_in = dden_q[j-1];
    end
    assign trial = {rem_in, nq_in[31]};
    assign diff = trial - {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      drem_q[j] <= diff[32] ? trial[31:0] : diff[31:0];
      dnq_q[j] <= {nq_in[30:0], ~diff[32]};
      dden_q[j] <= den_in;
    end
  end

  side_t side_q [0:SideN-1];
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{tf: tf_q[13], tc: tc_q[12], hum: hum12, inv: s12_inv_q, dbl: s12_dbl_q};
    for (int k = 1; k < SideN; k++) side_q[k] <= side_q[k-1];
  end

  logic [31:0] pr45_q, sq45_q, pr46_q, prq;
  word_t v2m45_q, v1m46_q, v2_46_q, fin47;
  assign prq = side_q[DivN-1].dbl ? (dnq_q[DivN-1] << 1) : dnq_q[DivN-1];
  assign fin47 = word_t'(pr46_q)
                 + sdiv(sdiv(v1m46_q, 12) + v2_46_q + p7, 4);

  always_ff @(posedge clk_i) begin
    pr45_q <= prq;
    sq45_q <= {3'b0, prq[31:3]} * {3'b0, prq[31:3]};
    v2m45_q <= word_t'({2'b0, prq[31:2]}) * p8;
    pr46_q <= pr45_q;
    v1m46_q <= p9 * word_t'({13'b0, sq45_q[31:13]});
    v2_46_q <= sdiv(v2m45_q, 13);
    pressure_o <= side_q[SideN-2].inv ? 32'd0 : 32'(fin47);
  end

  assign busy_o = 1'b0;
  assign result_valid_o = vld_q[NStage];
  assign fine_temperature_o = side_q[SideN-1].tf;
  assign temperature_centi_o = side_q[SideN-1].tc;
  assign pressure_invalid_o = side_q[SideN-1].inv;
  assign humidity_value_o = side_q[SideN-1].hum;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##47 result_valid_o)
    else $error("result strobe missing after accepted transaction");
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && pressure_invalid_o) |-> (pressure_o == 32'd0))
    else $error("pressure not forced to zero on zero divisor");
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (humidity_value_o <= 17'd100000))
    else $error("humidity out of range");

endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
  import esc_pkg::*;

  typedef struct {
    int          tf;
    int          tc;
    int unsigned pa;
    bit          inv;
    bit [16:0]   hum;
  } sample_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [19:0]         raw_t;
  logic [19:0]         raw_p;
  logic [15:0]         raw_h;
  logic                cfg_we;
  logic [IdxW-1:0]     cfg_idx;
  logic [CalW-1:0]     cfg_wdata;
  logic                res_valid;
  logic signed [31:0]  res_tf;
  logic signed [31:0]  res_tc;
  logic [31:0]         res_pa;
  logic                res_inv;
  logic [16:0]         res_hum;

  logic [47:0] cal_t, cal_pa, cal_pb, cal_pc;
  logic [31:0] cal_ha;
  logic [39:0] cal_hb;

  sample_t compensated_q[$];
  int      n_errors;
  int      idle_cycles;

  env_sensor_compensation dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start_i             (start),
    .busy_o              (busy),
    .raw_temperature_i   (raw_t),
    .raw_pressure_i      (raw_p),
    .raw_humidity_i      (raw_h),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .result_valid_o      (res_valid),
    .fine_temperature_o  (res_tf),
    .temperature_centi_o (res_tc),
    .pressure_o          (res_pa),
    .pressure_invalid_o  (res_inv),
    .humidity_value_o    (res_hum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int s16(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic sample_t compensate(int rt, int rp, int rh);
    sample_t     s;
    int          t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    int          h1, h2, h3, h4, h5, h6;
    int          a, b, d, tf, v1, v2, v3, v4, q, sq, tmp;
    int          t, x, y, z, base, c, g, m, n, r;
    int unsigned pr, dv, sq8;
    t1 = int'(cal_t[15:0]);  t2 = s16(cal_t[31:16]);  t3 = s16(cal_t[47:32]);
    p1 = int'(cal_pa[15:0]); p2 = s16(cal_pa[31:16]); p3 = s16(cal_pa[47:32]);
    p4 = s16(cal_pb[15:0]);  p5 = s16(cal_pb[31:16]); p6 = s16(cal_pb[47:32]);
    p7 = s16(cal_pc[15:0]);  p8 = s16(cal_pc[31:16]); p9 = s16(cal_pc[47:32]);
    h1 = int'(cal_ha[7:0]);  h2 = s16(cal_ha[23:8]);  h3 = int'(cal_ha[31:24]);
    h4 = s16(cal_hb[15:0]);  h5 = s16(cal_hb[31:16]);
    h6 = int'($signed(cal_hb[39:32]));

    a = ((rt / 8) - t1 * 2) * t2 / 2048;
    d = rt / 16 - t1;
    b = ((d * d) / 4096) * t3 / 16384;
    tf = a + b;
    s.tf = tf;
    s.tc = (tf * 5 + 128) / 256;

    v1 = tf / 2 - 64000;
    q = v1 / 4;
    sq = q * q;
    v2 = (sq / 2048) * p6;
    v2 = v2 + v1 * p5 * 2;
    v2 = v2 / 4 + p4 * 65536;
    v3 = (p3 * (sq / 8192)) / 8;
    v4 = (p2 * v1) / 2;
    v1 = (v3 + v4) / 262144;
    v1 = ((32768 + v1) * p1) / 32768;
    if (v1 == 0) begin
      s.inv = 1'b1;
      s.pa = 0;
    end else begin
      s.inv = 1'b0;
      dv = unsigned'(v1);
      tmp = v2 / 4096;
      pr = (32'd1048576 - unsigned'(rp) - unsigned'(tmp)) * 32'd3125;
      pr = (pr < 32'h8000_0000) ? (pr << 1) / dv : (pr / dv) * 32'd2;
      sq8 = ((pr / 8) * (pr / 8)) / 8192;
      v1 = (p9 * int'(sq8)) / 4096;
      v2 = (int'(pr / 4) * p8) / 8192;
      s.pa = unsigned'(int'(pr) + (v1 + v2 + p7) / 16);
    end

    t = tf - 76800;
    x = rh * 16384;
    y = h4 * 1048576;
    z = h5 * t;
    base = (x - y - z + 16384) / 32768;
    a = (t * h6) / 1024;
    b = (t * h3) / 2048;
    c = (a * (b + 32768)) / 1024 + 2097152;
    g = (c * h2 + 8192) / 16384;
    m = base * g;
    n = ((m / 32768) * (m / 32768)) / 128;
    r = m - (n * h1) / 16;
    if (r < 0) s.hum = 0;
    else if (r > 409600000) s.hum = 17'd100000;
    else s.hum = 17'(r / 4096);
    return s;
  endfunction

  // queue expectations on every accepted transaction, check every result
  always @(posedge clk) begin
    sample_t e;
    if (rst_n) begin
      if ((start && !busy) || res_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        compensated_q.push_back(compensate(int'(raw_t), int'(raw_p), int'(raw_h)));
      end
      if (res_valid) begin
        if (compensated_q.size() == 0) begin
          $error("result with nothing expected");
          n_errors++;
        end else begin
          e = compensated_q.pop_front();
          if (res_tf !== e.tf) begin
            $error("fine_temperature exp %0d got %0d", e.tf, res_tf); n_errors++;
          end
          if (res_tc !== e.tc) begin
            $error("temperature_centi exp %0d got %0d", e.tc, res_tc); n_errors++;
          end
          if (res_pa !== e.pa) begin
            $error("pressure exp %0d got %0d", e.pa, res_pa); n_errors++;
          end
          if (res_inv !== e.inv) begin
            $error("pressure_invalid exp %0d got %0d", e.inv, res_inv); n_errors++;
          end
          if (res_hum !== e.hum) begin
            $error("humidity_value exp %0d got %0d", e.hum, res_hum); n_errors++;
          end
        end
      end
      if (idle_cycles > 3000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_sample(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    raw_t <= t;
    raw_p <= p;
    raw_h <= h;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (compensated_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cal(logic [IdxW-1:0] idx, logic [CalW-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegTempCal:   cal_t = v;
      RegPressCalA: cal_pa = v;
      RegPressCalB: cal_pb = v;
      RegPressCalC: cal_pc = v;
      RegHumCalA:   cal_ha = v[31:0];
      RegHumCalB:   cal_hb = v[39:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic load_typical();
    write_cal(RegTempCal, {16'(-1000), 16'(26435), 16'(27504)});
    write_cal(RegPressCalA, {16'(3024), 16'(-10685), 16'(36477)});
    write_cal(RegPressCalB, {16'(-7), 16'(140), 16'(2855)});
    write_cal(RegPressCalC, {16'(6000), 16'(-14600), 16'(15500)});
    write_cal(RegHumCalA, {16'hffff, 8'd0, 16'(362), 8'd75});
    write_cal(RegHumCalB, {8'hab, 8'(30), 16'(50), 16'(313)});
  endtask

  task automatic random_samples(int count);
    repeat (count) begin
      if ($urandom_range(0, 2) == 0)
        send_sample(20'($urandom), 20'($urandom), 16'($urandom));
      else
        send_sample(20'($urandom_range(400000, 640000)), 20'($urandom_range(250000, 600000)),
                    16'($urandom_range(15000, 50000)));
    end
  endtask

  task automatic test_reset_values();
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    drain();
  endtask

  task automatic test_directed_typical();
    load_typical();
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'h80000, 20'h80000, 16'h8000);
    send_sample(20'd519888, '0, '1);
    send_sample(20'd519888, '1, '0);
    send_sample(20'd300000, 20'd300000, 16'd65535);
    send_sample(20'd700000, 20'd700000, 16'd1);
    drain();
    // out of range indexes are dropped
    write_cal(3'd6, '1);
    write_cal(3'd7, '1);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    drain();
  endtask

  task automatic test_zero_divisor();
    write_cal(RegPressCalA, {16'(3024), 16'(-10685), 16'(0)});
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample('1, '0, '1);
    drain();
  endtask

  task automatic test_all_ones_cal();
    for (int i = 0; i < 6; i++) write_cal(IdxW'(i), '1);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    random_samples(40);
    drain();
  endtask

  task automatic test_random();
    load_typical();
    random_samples(200);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 6; i++)
        if ($urandom_range(0, 1) == 0) write_cal(IdxW'(i), rand48());
      random_samples(70);
      drain();
    end
  endtask

  initial begin
    n_errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    raw_t = '0;
    raw_p = '0;
    raw_h = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_ha = '0; cal_hb = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed_typical();
    test_zero_divisor();
    test_all_ones_cal();
    test_random();
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
